// ===== hdl/vskt_pkg.sv =====
// Shared types and codes for the value-sorted key table.
// Request and result payload structs, operation and status codes, parameter defaults.
// No dependencies.
package vskt_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int KEY_BITS_DEF   = 64;
  localparam int VALUE_BITS_DEF = 32;

  // Fixed port field widths
  localparam int KEY_IN_W    = 64;
  localparam int VALUE_IO_W  = 32;
  localparam int CNT_OUT_W   = 5;

  typedef logic [1:0] op_t;
  localparam op_t OP_LOOKUP = 2'd0;
  localparam op_t OP_INSERT = 2'd1;
  localparam op_t OP_DELETE = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t ST_DONE   = 2'd0;
  localparam status_t ST_DUP    = 2'd1;
  localparam status_t ST_FULL   = 2'd2;
  localparam status_t ST_ABSENT = 2'd3;

  typedef struct packed {
    op_t                           operation;
    logic [KEY_IN_W-1:0]           key;
    logic signed [VALUE_IO_W-1:0]  value;
  } req_t;

  typedef struct packed {
    logic                          found;
    logic signed [VALUE_IO_W-1:0]  value_out;
    status_t                       status;
    logic [CNT_OUT_W-1:0]          entry_count;
    logic                          is_empty;
    logic                          is_full;
  } res_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic do_ins;
    logic do_del;
  } cell_ctrl_t;

endpackage

// ===== hdl/vskt_cell.sv =====
// One slot of the sorted table: holds a key/value pair, matches keys,
// and shifts toward its neighbors on insert or delete. Depends on vskt_pkg.
module vskt_cell
  import vskt_pkg::*;
#(
  parameter int IDX        = 0,
  parameter int IDX_W      = 4,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  cell_ctrl_t                   ctrl,
  input  logic [IDX_W-1:0]             del_pos,
  input  logic [KEY_BITS-1:0]          new_key,
  input  logic signed [VALUE_BITS-1:0] new_val,
  input  logic                         occ,
  input  logic                         left_occ,
  input  logic                         left_moving,
  input  logic [KEY_BITS-1:0]          left_key,
  input  logic signed [VALUE_BITS-1:0] left_val,
  input  logic [KEY_BITS-1:0]          right_key,
  input  logic signed [VALUE_BITS-1:0] right_val,
  output logic [KEY_BITS-1:0]          key_q,
  output logic signed [VALUE_BITS-1:0] val_q,
  output logic                         hit,
  output logic                         moving
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic [KEY_BITS-1:0]          key_r, key_nxt;
  logic signed [VALUE_BITS-1:0] val_r, val_nxt;
  logic                         at_end;
  logic                         take_left, take_new, take_right;

  assign hit    = occ && (key_r == new_key);
  // occupied and smaller than the incoming value: shifts down on insert
  assign moving = occ && (new_val > val_r);
  // first free slot
  assign at_end = !occ && left_occ;

  assign take_left  = ctrl.do_ins && left_moving;
  assign take_new   = ctrl.do_ins && !left_moving && (moving || at_end);
  assign take_right = ctrl.do_del && (MY_IDX >= del_pos);

  always_comb begin
    key_nxt = key_r;
    val_nxt = val_r;
    if (take_left) begin
      key_nxt = left_key;
      val_nxt = left_val;
    end else if (take_new) begin
      key_nxt = new_key;
      val_nxt = new_val;
    end else if (take_right) begin
      key_nxt = right_key;
      val_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    val_r <= val_nxt;
  end

  assign key_q = key_r;
  assign val_q = val_r;

endmodule

// ===== hdl/value_sorted_key_table.sv =====
// Latency: the result of a request is registered at the edge that accepts it.
// Throughput: one request per cycle; the result register frees when out_ready is high.
// Every cell matches its key and shifts in the same cycle, so the row never stalls.
// Reset (rst_n low, synchronous): entry count cleared, result register empty.
// Slot contents are not cleared; slots at or above the count never reach a result.
module value_sorted_key_table
  import vskt_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_req,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  localparam int CW    = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  // Occupancy count; slots below it hold live entries in descending value order
  logic [CW-1:0] count_r, count_nxt;
  logic          out_valid_r, out_valid_nxt;
  res_t          out_r, res_nxt;

  logic                         acc;
  logic [KEY_BITS-1:0]          new_key;
  logic signed [VALUE_BITS-1:0] new_val;
  cell_ctrl_t                   ctrl;
  logic [IDX_W-1:0]             del_pos;
  logic                         any_hit, full;
  logic signed [VALUE_BITS-1:0] hit_val;

  logic [KEY_BITS-1:0]          key_q [DEPTH];
  logic signed [VALUE_BITS-1:0] val_q [DEPTH];
  logic [DEPTH-1:0]             hit, mov, occ;

  assign acc     = in_valid && in_ready;
  assign in_ready = !out_valid_r || out_ready;

  // Key truncated or zero-extended to the stored width; value narrowed or sign-extended
  assign new_key = KEY_BITS'(in_req.key);
  assign new_val = VALUE_BITS'(in_req.value);

  // ---- row of cells ----
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    localparam logic [CW-1:0] G_IDX = CW'(g);
    logic                         l_occ, l_mov;
    logic [KEY_BITS-1:0]          l_key, r_key;
    logic signed [VALUE_BITS-1:0] l_val, r_val;

    assign occ[g] = G_IDX < count_r;

    if (g == 0) begin : g_first
      assign l_occ = 1'b1;
      assign l_mov = 1'b0;
      assign l_key = new_key;
      assign l_val = new_val;
    end else begin : g_mid
      assign l_occ = occ[g-1];
      assign l_mov = mov[g-1];
      assign l_key = key_q[g-1];
      assign l_val = val_q[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign r_key = key_q[g];
      assign r_val = val_q[g];
    end else begin : g_inner
      assign r_key = key_q[g+1];
      assign r_val = val_q[g+1];
    end

    vskt_cell #(
      .IDX        (g),
      .IDX_W      (IDX_W),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .del_pos     (del_pos),
      .new_key     (new_key),
      .new_val     (new_val),
      .occ         (occ[g]),
      .left_occ    (l_occ),
      .left_moving (l_mov),
      .left_key    (l_key),
      .left_val    (l_val),
      .right_key   (r_key),
      .right_val   (r_val),
      .key_q       (key_q[g]),
      .val_q       (val_q[g]),
      .hit         (hit[g]),
      .moving      (mov[g])
    );
  end

  // Keys are unique among live slots, so the hit vector is one-hot or zero:
  // its index and value reduce to plain OR trees.
  always_comb begin
    del_pos = '0;
    hit_val = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (hit[i]) begin
        del_pos = del_pos | IDX_W'(i);
        hit_val = hit_val | val_q[i];
      end
    end
  end

  assign any_hit = |hit;
  assign full    = (count_r == FULL_CNT);

  // ---- command decode and result ----
  always_comb begin
    ctrl                = '0;
    count_nxt           = count_r;
    res_nxt             = '0;
    res_nxt.found       = any_hit;
    unique case (in_req.operation)
      OP_INSERT: begin
        if (any_hit) begin
          res_nxt.status = ST_DUP;
        end else if (full) begin
          res_nxt.status = ST_FULL;
        end else begin
          res_nxt.status = ST_DONE;
          ctrl.do_ins    = acc;
          if (acc) count_nxt = count_r + CW'(1);
        end
      end
      OP_DELETE: begin
        if (any_hit) begin
          res_nxt.status = ST_DONE;
          ctrl.do_del    = acc;
          if (acc) count_nxt = count_r - CW'(1);
        end else begin
          res_nxt.status = ST_ABSENT;
        end
      end
      default: begin
        // lookup; the spare code behaves the same
        if (any_hit) begin
          res_nxt.status    = ST_DONE;
          res_nxt.value_out = VALUE_IO_W'(hit_val);
        end else begin
          res_nxt.status = ST_ABSENT;
        end
      end
    endcase
    res_nxt.entry_count = CNT_OUT_W'(count_nxt);
    res_nxt.is_empty    = (count_nxt == '0);
    res_nxt.is_full     = (count_nxt == FULL_CNT);
  end

  assign out_valid_nxt = acc || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("entry count above depth");

  a_hit_unique: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit))
    else $error("key present in more than one live slot");

  a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !acc |=> $stable(count_r))
    else $error("entry count moved without a request");

  a_full_refused: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_req.operation == OP_INSERT && full && !any_hit
    |=> out_valid_r && out_r.status == ST_FULL && $stable(count_r))
    else $error("insert into full table not refused");
`endif

endmodule

// ===== tb/tb_top.sv =====
// Testbench for value_sorted_key_table: directed corner requests, then random traffic.
// Holds its own sorted key/value table and checks every result against it.
// Depends on vskt_pkg and the value_sorted_key_table RTL.
`timescale 1ns / 100ps

module tb_top;
  import vskt_pkg::*;

  localparam int TABLE_DEPTH  = DEPTH_DEF;
  localparam int RANDOM_ITEMS = 1830;
  localparam int TAIL_ITEMS   = 200;     // no idling on either side for these
  localparam int PHASE_ITEMS  = 60;      // mix and gap rate are redrawn this often
  localparam int KEY_POOL_N   = 24;      // more keys than slots, so full and dup both occur
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam op_t OP_UNUSED   = 2'd3;    // decodes as a lookup

  // Checker: shadow copy of the table plus the queue of results still owed.
  class sorted_table_checker;
    logic [KEY_IN_W-1:0]          slot_key [TABLE_DEPTH];
    logic signed [VALUE_IO_W-1:0] slot_value [TABLE_DEPTH];
    int                           slot_count;
    res_t                         owed_results[$];
    int                           errors;

    function new();
      slot_count = 0;
      errors     = 0;
    endfunction

    task log_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("[%0t] MISMATCH %s: got %0h, want %0h", $time, what, got, want);
      errors++;
    endtask

    // Applies one accepted request to the shadow table and queues its result.
    function void take_request(req_t r);
      res_t e;
      bit   hit;
      int   pos;
      int   i;
      e   = '0;
      hit = 1'b0;
      pos = 0;
      for (i = 0; i < slot_count; i++) begin
        if (!hit && slot_key[i] == r.key) begin
          hit = 1'b1;
          pos = i;
        end
      end
      case (r.operation)
        OP_INSERT: begin
          if (hit) begin
            e.status = ST_DUP;
          end else if (slot_count >= TABLE_DEPTH) begin
            e.status = ST_FULL;
          end else begin
            // new entry lands behind every entry of equal or greater value
            i = slot_count;
            while (i > 0 && r.value > slot_value[i-1]) begin
              slot_key[i]   = slot_key[i-1];
              slot_value[i] = slot_value[i-1];
              i--;
            end
            slot_key[i]   = r.key;
            slot_value[i] = r.value;
            slot_count++;
            e.status = ST_DONE;
          end
        end
        OP_DELETE: begin
          if (hit) begin
            for (i = pos; i + 1 < slot_count; i++) begin
              slot_key[i]   = slot_key[i+1];
              slot_value[i] = slot_value[i+1];
            end
            slot_count--;
            e.status = ST_DONE;
          end else begin
            e.status = ST_ABSENT;
          end
        end
        default: begin
          if (hit) begin
            e.value_out = slot_value[pos];
            e.status    = ST_DONE;
          end else begin
            e.status = ST_ABSENT;
          end
        end
      endcase
      e.found       = hit;
      e.entry_count = slot_count[CNT_OUT_W-1:0];
      e.is_empty    = (slot_count == 0);
      e.is_full     = (slot_count >= TABLE_DEPTH);
      owed_results.push_back(e);
    endfunction

    task check_result(res_t got);
      res_t want;
      if (owed_results.size() == 0) begin
        log_mismatch("result with no request outstanding", 64'(got), 64'(0));
        return;
      end
      want = owed_results.pop_front();
      if (got.found !== want.found)
        log_mismatch("found", 64'(got.found), 64'(want.found));
      if (got.value_out !== want.value_out)
        log_mismatch("value_out", 64'(got.value_out), 64'(want.value_out));
      if (got.status !== want.status)
        log_mismatch("status", 64'(got.status), 64'(want.status));
      if (got.entry_count !== want.entry_count)
        log_mismatch("entry_count", 64'(got.entry_count), 64'(want.entry_count));
      if (got.is_empty !== want.is_empty)
        log_mismatch("is_empty", 64'(got.is_empty), 64'(want.is_empty));
      if (got.is_full !== want.is_full)
        log_mismatch("is_full", 64'(got.is_full), 64'(want.is_full));
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  req_t in_req;
  logic out_valid;
  logic out_ready;
  res_t out_res;

  sorted_table_checker table_chk;
  logic [KEY_IN_W-1:0] key_pool [KEY_POOL_N];
  bit  tail_quiet   = 1'b0;
  int  send_gap_pct = 0;
  int  stall_pct    = 0;
  int  cycle_count  = 0;

  value_sorted_key_table #(
    .DEPTH      (TABLE_DEPTH),
    .KEY_BITS   (KEY_BITS_DEF),
    .VALUE_BITS (VALUE_BITS_DEF)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Both handshakes are sampled at the rising edge. A result always belongs to
  // a request from an earlier edge, so the order of the two calls is free.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) table_chk.check_result(out_res);
      if (in_valid && in_ready) table_chk.take_request(in_req);
    end
  end

  // Hard stop in case a handshake hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side backpressure: out_ready is dropped in bursts, with the stall rate
  // redrawn among 0, 8 and 30 percent so that some stretches never stall at all.
  initial begin : result_sink
    int n;
    n         = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      n++;
      if (n % 150 == 0) begin
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 8;
          default: stall_pct = 30;
        endcase
      end
      if (!tail_quiet && $urandom_range(0, 99) < stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  function automatic req_t make_request(op_t op, logic [KEY_IN_W-1:0] key,
                                        logic signed [VALUE_IO_W-1:0] value);
    req_t r;
    r.operation = op;
    r.key       = key;
    r.value     = value;
    return r;
  endfunction

  // Random request: keys mostly from a small pool so hits, duplicates and a
  // full table are common; values often tiny so equal values pile up.
  function automatic req_t random_request(int insert_pct);
    op_t                          op;
    logic [KEY_IN_W-1:0]          key;
    logic signed [VALUE_IO_W-1:0] value;
    int                           pick;
    if ($urandom_range(0, 99) < insert_pct) begin
      op = OP_INSERT;
    end else begin
      pick = $urandom_range(0, 19);
      if (pick < 9)       op = OP_LOOKUP;
      else if (pick < 18) op = OP_DELETE;
      else                op = OP_UNUSED;
    end
    if ($urandom_range(0, 4) == 0) key = {$urandom, $urandom};
    else                           key = key_pool[$urandom_range(0, KEY_POOL_N - 1)];
    if ($urandom_range(0, 9) < 4) value = $signed($urandom_range(0, 6)) - 3;
    else                          value = $urandom;
    return make_request(op, key, value);
  endfunction

  // Drives one request at the falling edge, optionally after an idle burst, and
  // returns at the falling edge after it has been accepted. Valid is only
  // lowered on a gap, so back-to-back requests keep it high.
  task automatic issue(req_t r);
    if (!tail_quiet && $urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  initial begin : stimulus
    int i;
    int insert_pct;
    in_valid  = 1'b0;
    in_req    = '0;
    rst_n     = 1'b0;
    insert_pct = 50;
    table_chk = new();
    for (i = 0; i < KEY_POOL_N; i++) key_pool[i] = {$urandom, $urandom};

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty table: misses on lookup, delete and the spare opcode.
    issue(make_request(OP_LOOKUP, '0, 32'sd7));
    issue(make_request(OP_DELETE, '1, 32'sd0));
    issue(make_request(OP_UNUSED, '0, -32'sd1));
    // Extreme keys and values; the max value must move to the front.
    issue(make_request(OP_INSERT, '0, 32'sd0));
    issue(make_request(OP_INSERT, '1, 32'sh7fffffff));
    issue(make_request(OP_INSERT, '0, 32'sd5));              // duplicate key
    issue(make_request(OP_INSERT, 64'd2, 32'sh80000000));
    issue(make_request(OP_LOOKUP, '1, 32'sd0));
    issue(make_request(OP_UNUSED, 64'd2, 32'sd0));           // spare op hits like a lookup
    // Fill to capacity with repeated values so ties keep arrival order.
    for (i = 0; i < TABLE_DEPTH - 3; i++)
      issue(make_request(OP_INSERT, 64'h10 + i, $signed(i % 3) - 1));
    issue(make_request(OP_INSERT, 64'h99, 32'sd1));          // refused, table full
    issue(make_request(OP_INSERT, '0, 32'sd1));              // duplicate wins over full
    issue(make_request(OP_DELETE, '1, 32'sd0));
    issue(make_request(OP_DELETE, '1, 32'sd0));              // already gone
    issue(make_request(OP_INSERT, 64'h99, -32'sd1));         // lands after the equal -1s
    issue(make_request(OP_LOOKUP, 64'h99, 32'sd3));

    // Random part. Phases lean toward filling, draining or neither so the
    // count sweeps the whole range; the sender's gap rate changes with them.
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % PHASE_ITEMS == 0) begin
        case ($urandom_range(0, 2))
          0:       insert_pct = 75;
          1:       insert_pct = 50;
          default: insert_pct = 25;
        endcase
        case ($urandom_range(0, 2))
          0:       send_gap_pct = 0;
          1:       send_gap_pct = 10;
          default: send_gap_pct = 35;
        endcase
      end
      if (i == RANDOM_ITEMS - TAIL_ITEMS) tail_quiet = 1'b1;
      issue(random_request(insert_pct));
    end
    in_valid <= 1'b0;

    // Wait for every owed result, then run on for DRAIN_CYCLES to catch strays.
    while (table_chk.owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (table_chk.errors == 0 && table_chk.owed_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
